[sv/lmst_pkg.sv]
`default_nettype none
package lmst_pkg;

    localparam int DEST_MAX_DEF    = 200;
    localparam int MAX_LINKS_DEF   = 32;
    localparam int OFFSET_BITS_DEF = 16;

    localparam int MAX_RES = 3;

    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_LBRK   = 8'h5B;
    localparam logic [7:0] CH_RBRK   = 8'h5D;
    localparam logic [7:0] CH_LPAR   = 8'h28;
    localparam logic [7:0] CH_RPAR   = 8'h29;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;

    localparam logic [1:0] KIND_TEXT   = 2'd0;
    localparam logic [1:0] KIND_TARGET = 2'd1;
    localparam logic [1:0] KIND_RECORD = 2'd2;
    localparam logic [1:0] KIND_END    = 2'd3;

    localparam logic [1:0] REG_BOLD   = 2'd0;
    localparam logic [1:0] REG_UNBOLD = 2'd1;
    localparam logic [1:0] REG_LINK   = 2'd2;
    localparam logic [1:0] REG_UNLINK = 2'd3;

    localparam logic [7:0] BOLD_RST   = 8'd1;
    localparam logic [7:0] UNBOLD_RST = 8'd2;
    localparam logic [7:0] LINK_RST   = 8'd3;
    localparam logic [7:0] UNLINK_RST = 8'd4;

    typedef struct packed {
        logic [7:0] bold_code;
        logic [7:0] unbold_code;
        logic [7:0] link_code;
        logic [7:0] unlink_code;
    } cfg_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  data;
        logic [4:0]  index;
        logic [15:0] start_pos;
        logic [15:0] end_pos;
    } rec_t;

endpackage
`default_nettype wire

[sv/lmst_core.sv]
`default_nettype none
module lmst_core
    import lmst_pkg::*;
#(
    parameter int DEST_MAX    = DEST_MAX_DEF,
    parameter int MAX_LINKS   = MAX_LINKS_DEF,
    parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    take,
    input  wire logic [7:0]              char_in,
    input  wire logic                    end_of_text,
    input  wire cfg_t                    cfg,
    output rec_t [MAX_RES-1:0]           res,
    output logic [1:0]                   res_cnt
);

    localparam int LINK_CNT_W = $clog2(MAX_LINKS + 1);
    localparam logic [OFFSET_BITS-1:0] OFF_ONE = {{(OFFSET_BITS-1){1'b0}}, 1'b1};

    logic hdr_reg, hdr_next;
    logic bold_reg, bold_next;
    logic link_reg, link_next;
    logic esc_reg, esc_next;
    logic skip_reg, skip_next;
    logic acb_reg, acb_next;
    logic cap_reg, cap_next;
    logic [7:0] tlen_reg, tlen_next;
    logic [OFFSET_BITS-1:0] off_reg, off_next;
    logic [OFFSET_BITS-1:0] open_reg, open_next;
    logic [OFFSET_BITS-1:0] close_reg, close_next;
    logic [LINK_CNT_W-1:0] lcnt_reg, lcnt_next;

    logic [OFFSET_BITS-1:0] off1, off2;
    logic [1:0] tx_n;
    logic [7:0] tx_b0, tx_b1;
    logic sp_en;
    rec_t sp;
    rec_t end_rec;
    logic handled;
    logic normal;

    assign off1 = (off_reg == '1) ? off_reg : off_reg + OFF_ONE;
    assign off2 = (off1 == '1) ? off1 : off1 + OFF_ONE;

    always_comb begin
        hdr_next   = hdr_reg;
        bold_next  = bold_reg;
        link_next  = link_reg;
        esc_next   = esc_reg;
        skip_next  = skip_reg;
        acb_next   = acb_reg;
        cap_next   = cap_reg;
        tlen_next  = tlen_reg;
        open_next  = open_reg;
        close_next = close_reg;
        lcnt_next  = lcnt_reg;
        tx_n       = 2'd0;
        tx_b0      = 8'd0;
        tx_b1      = 8'd0;
        sp_en      = 1'b0;
        sp         = '0;
        handled    = 1'b0;
        normal     = 1'b0;

        if (cap_reg) begin
            if (char_in == CH_RPAR || tlen_reg >= 8'(DEST_MAX)) begin
                cap_next = 1'b0;
                if (lcnt_reg < LINK_CNT_W'(MAX_LINKS)) begin
                    sp_en        = 1'b1;
                    sp.kind      = KIND_RECORD;
                    sp.index     = 5'(lcnt_reg);
                    sp.start_pos = 16'(open_reg);
                    sp.end_pos   = 16'(close_reg);
                    lcnt_next    = lcnt_reg + LINK_CNT_W'(1);
                end
            end else begin
                sp_en     = 1'b1;
                sp.kind   = KIND_TARGET;
                sp.data   = char_in;
                tlen_next = tlen_reg + 8'd1;
            end
        end else if (esc_reg) begin
            esc_next = 1'b0;
            tx_n     = 2'd1;
            tx_b0    = char_in;
        end else begin
            if (acb_reg) begin
                acb_next = 1'b0;
                if (char_in == CH_LPAR) begin
                    cap_next  = 1'b1;
                    tlen_next = 8'd0;
                    handled   = 1'b1;
                end
            end
            if (!handled && skip_reg) begin
                if (char_in == CH_HASH || char_in == CH_SPACE) begin
                    handled = 1'b1;
                end else begin
                    skip_next = 1'b0;
                end
            end
            normal = !handled;
        end

        if (normal) begin
            case (char_in)
                CH_BSLASH: begin
                    esc_next = 1'b1;
                end
                CH_HASH: begin
                    if (!hdr_reg) begin
                        tx_n  = 2'd1;
                        tx_b0 = cfg.bold_code;
                    end
                    hdr_next  = 1'b1;
                    skip_next = 1'b1;
                end
                CH_LBRK: begin
                    tx_n = 2'd1;
                    if (!link_reg) begin
                        open_next = off_reg;
                        tx_b0     = cfg.link_code;
                    end else begin
                        tx_b0 = char_in;
                    end
                    link_next = 1'b1;
                end
                CH_RBRK: begin
                    tx_n = 2'd1;
                    if (link_reg) begin
                        close_next = off_reg;
                        tx_b0      = cfg.unlink_code;
                        acb_next   = 1'b1;
                    end else begin
                        tx_b0 = char_in;
                    end
                    link_next = 1'b0;
                end
                CH_STAR: begin
                    tx_n      = 2'd1;
                    tx_b0     = bold_reg ? cfg.unbold_code : cfg.bold_code;
                    bold_next = !bold_reg;
                end
                CH_CR: begin
                end
                CH_LF: begin
                    if (hdr_reg) begin
                        hdr_next = 1'b0;
                        tx_n     = 2'd2;
                        tx_b0    = cfg.unbold_code;
                        tx_b1    = char_in;
                    end else begin
                        tx_n  = 2'd1;
                        tx_b0 = char_in;
                    end
                end
                default: begin
                    tx_n  = 2'd1;
                    tx_b0 = char_in;
                end
            endcase
        end

        case (tx_n)
            2'd1:    off_next = off1;
            2'd2:    off_next = off2;
            default: off_next = off_reg;
        endcase

        if (end_of_text) begin
            hdr_next   = 1'b0;
            bold_next  = 1'b0;
            link_next  = 1'b0;
            esc_next   = 1'b0;
            skip_next  = 1'b0;
            acb_next   = 1'b0;
            cap_next   = 1'b0;
            tlen_next  = '0;
            off_next   = '0;
            open_next  = '0;
            close_next = '0;
            lcnt_next  = '0;
        end
    end

    always_comb begin
        end_rec      = '0;
        end_rec.kind = KIND_END;
        res          = '0;
        res_cnt      = 2'd0;
        if (sp_en) begin
            res[0]  = sp;
            res_cnt = 2'd1;
        end else if (tx_n != 2'd0) begin
            res[0].kind = KIND_TEXT;
            res[0].data = tx_b0;
            res_cnt     = 2'd1;
            if (tx_n == 2'd2) begin
                res[1].kind = KIND_TEXT;
                res[1].data = tx_b1;
                res_cnt     = 2'd2;
            end
        end
        if (end_of_text) begin
            res[res_cnt] = end_rec;
            res_cnt      = res_cnt + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hdr_reg   <= 1'b0;
            bold_reg  <= 1'b0;
            link_reg  <= 1'b0;
            esc_reg   <= 1'b0;
            skip_reg  <= 1'b0;
            acb_reg   <= 1'b0;
            cap_reg   <= 1'b0;
            tlen_reg  <= '0;
            off_reg   <= '0;
            open_reg  <= '0;
            close_reg <= '0;
            lcnt_reg  <= '0;
        end else if (take) begin
            hdr_reg   <= hdr_next;
            bold_reg  <= bold_next;
            link_reg  <= link_next;
            esc_reg   <= esc_next;
            skip_reg  <= skip_next;
            acb_reg   <= acb_next;
            cap_reg   <= cap_next;
            tlen_reg  <= tlen_next;
            off_reg   <= off_next;
            open_reg  <= open_next;
            close_reg <= close_next;
            lcnt_reg  <= lcnt_next;
        end
    end

endmodule
`default_nettype wire

[sv/light_markup_to_styled_text_unit.sv]
`default_nettype none
// Channel   Direction  Handshake          Payload
// s_        in         s_valid/s_ready    s_char_in, s_end_of_text
// m_        out        m_valid/m_ready    m_out_kind, m_out_byte, m_link_index,
//                                         m_link_start_pos, m_link_end_pos, m_last_of_run
// apb       in         psel/penable       paddr, pwdata, prdata (marker codes)
//
// One markup byte per cycle while m_ready is high and each byte yields at most one result.
// A byte with two or three results holds the input until its last result goes: the
// result buffer sends one result per cycle while m_ready is high and takes the next byte on its last.
// Reset is synchronous on aresetn low; marker codes return to 1, 2, 3, 4.
// A stalled m_ready holds the buffer and, while it holds any result, the input.
module light_markup_to_styled_text_unit
    import lmst_pkg::*;
#(
    parameter int DEST_MAX    = DEST_MAX_DEF,
    parameter int MAX_LINKS   = MAX_LINKS_DEF,
    parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_char_in,
    input  wire logic        s_end_of_text,

    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [1:0]       m_out_kind,
    output logic [7:0]       m_out_byte,
    output logic [4:0]       m_link_index,
    output logic [15:0]      m_link_start_pos,
    output logic [15:0]      m_link_end_pos,
    output logic             m_last_of_run,

    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    cfg_t cfg_reg;
    rec_t [MAX_RES-1:0] res;
    logic [1:0] res_cnt;
    rec_t [MAX_RES-1:0] buf_reg;
    logic [1:0] cnt_reg;
    logic [1:0] ptr_reg;
    logic take;
    logic last_slot;
    logic pop;
    logic cfg_wr;
    logic [1:0] reg_idx;
    rec_t cur;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.bold_code   <= BOLD_RST;
            cfg_reg.unbold_code <= UNBOLD_RST;
            cfg_reg.link_code   <= LINK_RST;
            cfg_reg.unlink_code <= UNLINK_RST;
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_BOLD:   cfg_reg.bold_code   <= pwdata[7:0];
                REG_UNBOLD: cfg_reg.unbold_code <= pwdata[7:0];
                REG_LINK:   cfg_reg.link_code   <= pwdata[7:0];
                REG_UNLINK: cfg_reg.unlink_code <= pwdata[7:0];
                default:    cfg_reg.bold_code   <= cfg_reg.bold_code;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_BOLD:   prdata = {24'd0, cfg_reg.bold_code};
            REG_UNBOLD: prdata = {24'd0, cfg_reg.unbold_code};
            REG_LINK:   prdata = {24'd0, cfg_reg.link_code};
            REG_UNLINK: prdata = {24'd0, cfg_reg.unlink_code};
            default:    prdata = 32'd0;
        endcase
    end

    lmst_core #(
        .DEST_MAX    (DEST_MAX),
        .MAX_LINKS   (MAX_LINKS),
        .OFFSET_BITS (OFFSET_BITS)
    ) u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .take        (take),
        .char_in     (s_char_in),
        .end_of_text (s_end_of_text),
        .cfg         (cfg_reg),
        .res         (res),
        .res_cnt     (res_cnt)
    );

    assign m_valid   = (cnt_reg != 2'd0);
    assign last_slot = (ptr_reg == cnt_reg - 2'd1);
    assign pop       = m_valid && m_ready;
    assign s_ready   = !m_valid || (pop && last_slot);
    assign take      = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
            ptr_reg <= 2'd0;
        end else if (take) begin
            cnt_reg <= res_cnt;
            ptr_reg <= 2'd0;
        end else if (pop) begin
            if (last_slot) begin
                cnt_reg <= 2'd0;
                ptr_reg <= 2'd0;
            end else begin
                ptr_reg <= ptr_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            buf_reg <= res;
        end
    end

    assign cur              = buf_reg[ptr_reg];
    assign m_out_kind       = cur.kind;
    assign m_out_byte       = cur.data;
    assign m_link_index     = cur.index;
    assign m_link_start_pos = cur.start_pos;
    assign m_link_end_pos   = cur.end_pos;
    assign m_last_of_run    = last_slot;

endmodule
`default_nettype wire
